@@ hw/rtl/rpn_pkg.sv @@
// Shared types and constants of the RPN stack calculator.
`default_nettype none
package rpn_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int DIV_STEPS = 48;

    typedef enum logic [3:0] {
        CMD_PUSH  = 4'd0,
        CMD_PEEK  = 4'd1,
        CMD_DUP   = 4'd2,
        CMD_SWAP  = 4'd3,
        CMD_CLEAR = 4'd4,
        CMD_ADD   = 4'd5,
        CMD_MUL   = 4'd6,
        CMD_SUB   = 4'd7,
        CMD_NEG   = 4'd8,
        CMD_DIV   = 4'd9,
        CMD_MOD   = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZDIV  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SRC_VALUE,
        SRC_A,
        SRC_B,
        SRC_RES
    } t_push_src;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_EXEC,
        ALU_MSAT,
        ALU_DLOAD,
        ALU_DSTEP,
        ALU_DFIN
    } t_alu_op;

    typedef struct packed {
        logic      load;
        logic      clr_sp;
        logic      peek_chk;
        logic      pop_req;
        logic      pop_cap;
        logic      pop_to_a;
        logic      flag_zdiv;
        logic      push;
        t_push_src push_src;
        t_alu_op   alu;
        t_cmd      cmd;
        logic      top_req;
        logic      top_cap;
        logic      out_load;
    } t_dp_ctl;

    typedef struct packed {
        logic pop_zero;
        logic div_done;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ hw/rtl/rpn_cmd_if.sv @@
// Command channel: valid/ready handshake carrying command and operand.
`default_nettype none
interface rpn_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rpn_res_if.sv @@
// Result channel: valid/ready handshake carrying top, depth and status.
`default_nettype none
interface rpn_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] top;
    logic [7:0]  depth;
    logic [1:0]  status;

    modport source (output valid, output top, output depth, output status, input ready);
    modport sink   (input valid, input top, input depth, input status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rpn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/rpn_ctrl.sv @@
// Sequencer: walks each command through pops, ALU work, pushes and top read.
`default_nettype none
module rpn_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [3:0]      i_in_command,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output rpn_pkg::t_dp_ctl     o_ctl,
    input  wire rpn_pkg::t_dp_sts i_sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_POP_REQ, S_POP_CAP, S_EXEC, S_MSAT, S_DLOAD, S_DSTEP,
        S_DFIN, S_PUSH, S_TOP_REQ, S_TOP_CAP, S_DONE
    } t_state;

    t_state        r_state, n_state;
    rpn_pkg::t_cmd r_cmd, n_cmd;
    logic          r_nth, n_nth;
    logic          r_ovalid, n_ovalid;
    logic          two_pop, div_mod;
    rpn_pkg::t_cmd in_cmd;

    assign in_cmd  = rpn_pkg::t_cmd'(i_in_command);
    assign two_pop = (r_cmd == rpn_pkg::CMD_SWAP) || (r_cmd == rpn_pkg::CMD_ADD) ||
                     (r_cmd == rpn_pkg::CMD_MUL) || (r_cmd == rpn_pkg::CMD_SUB);
    assign div_mod = (r_cmd == rpn_pkg::CMD_DIV) || (r_cmd == rpn_pkg::CMD_MOD);

    always_comb begin
        o_ctl      = '0;
        o_ctl.cmd  = r_cmd;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_nth      = r_nth;
        // binary ops pop b then a; swap pops into a first
        if (r_cmd == rpn_pkg::CMD_SWAP) begin
            o_ctl.pop_to_a = !r_nth;
        end else if (r_cmd == rpn_pkg::CMD_DUP || r_cmd == rpn_pkg::CMD_NEG) begin
            o_ctl.pop_to_a = 1'b1;
        end else begin
            o_ctl.pop_to_a = r_nth;
        end
        case (r_cmd)
            rpn_pkg::CMD_PUSH: o_ctl.push_src = rpn_pkg::SRC_VALUE;
            rpn_pkg::CMD_DUP:  o_ctl.push_src = rpn_pkg::SRC_A;
            rpn_pkg::CMD_SWAP: o_ctl.push_src = r_nth ? rpn_pkg::SRC_B : rpn_pkg::SRC_A;
            default:           o_ctl.push_src = rpn_pkg::SRC_RES;
        endcase

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load     = 1'b1;
                    o_ctl.clr_sp   = (in_cmd == rpn_pkg::CMD_CLEAR);
                    o_ctl.peek_chk = (in_cmd == rpn_pkg::CMD_PEEK);
                    n_cmd = in_cmd;
                    n_nth = 1'b0;
                    case (in_cmd)
                        rpn_pkg::CMD_PUSH: n_state = S_PUSH;
                        rpn_pkg::CMD_DUP, rpn_pkg::CMD_SWAP, rpn_pkg::CMD_ADD,
                        rpn_pkg::CMD_MUL, rpn_pkg::CMD_SUB, rpn_pkg::CMD_NEG,
                        rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: n_state = S_POP_REQ;
                        default: n_state = S_TOP_REQ;
                    endcase
                end
            end
            S_POP_REQ: begin
                o_ctl.pop_req = 1'b1;
                n_state = S_POP_CAP;
            end
            S_POP_CAP: begin
                o_ctl.pop_cap = 1'b1;
                if (!r_nth && two_pop) begin
                    n_nth   = 1'b1;
                    n_state = S_POP_REQ;
                end else if (!r_nth && div_mod) begin
                    if (i_sts.pop_zero) begin
                        o_ctl.flag_zdiv = 1'b1;
                        n_state = S_TOP_REQ;
                    end else begin
                        n_nth   = 1'b1;
                        n_state = S_POP_REQ;
                    end
                end else begin
                    n_nth = 1'b0;
                    case (r_cmd)
                        rpn_pkg::CMD_DUP, rpn_pkg::CMD_SWAP: n_state = S_PUSH;
                        rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_NEG,
                        rpn_pkg::CMD_MUL: n_state = S_EXEC;
                        rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: n_state = S_DLOAD;
                        default: n_state = S_TOP_REQ;
                    endcase
                end
            end
            S_EXEC: begin
                o_ctl.alu = rpn_pkg::ALU_EXEC;
                n_state = (r_cmd == rpn_pkg::CMD_MUL) ? S_MSAT : S_PUSH;
            end
            S_MSAT: begin
                o_ctl.alu = rpn_pkg::ALU_MSAT;
                n_state = S_PUSH;
            end
            S_DLOAD: begin
                o_ctl.alu = rpn_pkg::ALU_DLOAD;
                n_state = S_DSTEP;
            end
            S_DSTEP: begin
                o_ctl.alu = rpn_pkg::ALU_DSTEP;
                if (i_sts.div_done) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_ctl.alu = rpn_pkg::ALU_DFIN;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_ctl.push = 1'b1;
                if ((r_cmd == rpn_pkg::CMD_DUP || r_cmd == rpn_pkg::CMD_SWAP) && !r_nth) begin
                    n_nth = 1'b1;
                end else begin
                    n_state = S_TOP_REQ;
                end
            end
            S_TOP_REQ: begin
                o_ctl.top_req = 1'b1;
                n_state = S_TOP_CAP;
            end
            S_TOP_CAP: begin
                o_ctl.top_cap = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_ctl.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd    <= rpn_pkg::CMD_PUSH;
            r_nth    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_nth    <= n_nth;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
endmodule
`default_nettype wire

@@ hw/rtl/rpn_dp.sv @@
// Datapath: stack pointer, stack RAM, operand registers, ALU and divider.
`default_nettype none
module rpn_dp #(
    parameter int DEPTH = rpn_pkg::DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rpn_pkg::t_dp_ctl  i_ctl,
    input  wire logic [31:0]       i_value,
    output rpn_pkg::t_dp_sts       o_sts,
    output logic [31:0]            o_top,
    output logic [7:0]             o_depth,
    output logic [1:0]             o_status
);
    localparam int AW  = $clog2(DEPTH);
    localparam int SPW = $clog2(DEPTH + 1);
    localparam int CW  = $clog2(rpn_pkg::DIV_STEPS + 1);
    localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] QMIN = 32'h8000_0000;

    logic [SPW-1:0]   r_sp, n_sp, sp_m1;
    rpn_pkg::t_status r_status, n_status;
    logic [31:0]      r_value, r_a, r_b, r_res, r_top;
    logic [63:0]      r_prod;
    logic             r_neg, r_hit;
    logic [31:0]      r_rem;
    logic [47:0]      r_quo;
    logic [31:0]      r_dvs;
    logic [CW-1:0]    r_cnt;

    logic             sp_zero, sp_full, ram_we, ram_re;
    logic [31:0]      ram_wdata, ram_rdata, pop_val, ma, mb;
    logic [32:0]      sum, dif, neg_a, rem_sh;
    logic [33:0]      trial;

    function automatic logic [31:0] sat33(input logic [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? QMIN : QMAX;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] ssat(input logic [47:0] m, input logic neg);
        if (neg) begin
            return (m >= 48'h0000_8000_0000) ? QMIN : (32'd0 - m[31:0]);
        end
        return (m > 48'h0000_7FFF_FFFF) ? QMAX : m[31:0];
    endfunction

    assign sp_zero = (r_sp == '0);
    assign sp_full = (r_sp == SPW'(DEPTH));
    assign sp_m1   = r_sp - SPW'(1);
    assign ram_we  = i_ctl.push && !sp_full;
    assign ram_re  = (i_ctl.pop_req || i_ctl.top_req) && !sp_zero;
    assign pop_val = r_hit ? ram_rdata : 32'd0;

    always_comb begin
        case (i_ctl.push_src)
            rpn_pkg::SRC_VALUE: ram_wdata = r_value;
            rpn_pkg::SRC_A:     ram_wdata = r_a;
            rpn_pkg::SRC_B:     ram_wdata = r_b;
            default:            ram_wdata = r_res;
        endcase
    end

    rpn_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_sp[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (sp_m1[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ma     = r_a[31] ? (~r_a + 32'd1) : r_a;
    assign mb     = r_b[31] ? (~r_b + 32'd1) : r_b;
    assign sum    = {r_a[31], r_a} + {r_b[31], r_b};
    assign dif    = {r_a[31], r_a} - {r_b[31], r_b};
    assign neg_a  = 33'd0 - {r_a[31], r_a};
    assign rem_sh = {r_rem, r_quo[47]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_dvs};

    always_comb begin
        n_sp = r_sp;
        if (i_ctl.clr_sp) begin
            n_sp = '0;
        end else if (i_ctl.pop_req && !sp_zero) begin
            n_sp = sp_m1;
        end else if (ram_we) begin
            n_sp = r_sp + SPW'(1);
        end

        // keep the first error of the step
        n_status = r_status;
        if (i_ctl.load) begin
            n_status = (i_ctl.peek_chk && sp_zero) ? rpn_pkg::ST_EMPTY : rpn_pkg::ST_OK;
        end else if (r_status == rpn_pkg::ST_OK) begin
            if (i_ctl.pop_req && sp_zero) begin
                n_status = rpn_pkg::ST_EMPTY;
            end else if (i_ctl.push && sp_full) begin
                n_status = rpn_pkg::ST_FULL;
            end else if (i_ctl.flag_zdiv) begin
                n_status = rpn_pkg::ST_ZDIV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_status <= rpn_pkg::ST_OK;
            r_cnt    <= '0;
        end else begin
            r_sp     <= n_sp;
            r_status <= n_status;
            if (i_ctl.alu == rpn_pkg::ALU_DLOAD) begin
                r_cnt <= CW'(rpn_pkg::DIV_STEPS);
            end else if (i_ctl.alu == rpn_pkg::ALU_DSTEP && r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= i_value;
        end
        if (i_ctl.pop_req || i_ctl.top_req) begin
            r_hit <= !sp_zero;
        end
        if (i_ctl.pop_cap) begin
            if (i_ctl.pop_to_a) begin
                r_a <= pop_val;
            end else begin
                r_b <= pop_val;
            end
        end
        if (i_ctl.top_cap) begin
            r_top <= pop_val;
        end
        case (i_ctl.alu)
            rpn_pkg::ALU_EXEC: begin
                r_prod <= ma * mb;
                r_neg  <= r_a[31] ^ r_b[31];
                case (i_ctl.cmd)
                    rpn_pkg::CMD_ADD: r_res <= sat33(sum);
                    rpn_pkg::CMD_SUB: r_res <= sat33(dif);
                    rpn_pkg::CMD_NEG: r_res <= sat33(neg_a);
                    default:          r_res <= r_res;
                endcase
            end
            rpn_pkg::ALU_MSAT: begin
                r_res <= ssat(r_prod[63:16], r_neg);
            end
            rpn_pkg::ALU_DLOAD: begin
                r_dvs <= mb;
                r_rem <= '0;
                if (i_ctl.cmd == rpn_pkg::CMD_DIV) begin
                    r_quo <= {ma, 16'd0};
                    r_neg <= r_a[31] ^ r_b[31];
                end else begin
                    r_quo <= {16'd0, ma};
                    r_neg <= r_a[31];
                end
            end
            rpn_pkg::ALU_DSTEP: begin
                // restoring division, one quotient bit per cycle
                if (r_cnt != '0) begin
                    r_rem <= trial[33] ? rem_sh[31:0] : trial[31:0];
                    r_quo <= {r_quo[46:0], !trial[33]};
                end
            end
            rpn_pkg::ALU_DFIN: begin
                if (i_ctl.cmd == rpn_pkg::CMD_DIV) begin
                    r_res <= ssat(r_quo, r_neg);
                end else begin
                    r_res <= ssat({16'd0, r_rem}, r_neg);
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
        if (i_ctl.out_load) begin
            o_top    <= r_top;
            o_depth  <= 8'(r_sp);
            o_status <= r_status;
        end
    end

    assign o_sts.pop_zero = !r_hit || (ram_rdata == 32'd0);
    assign o_sts.div_done = (r_cnt == '0);

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(DEPTH))
        else $error("stack pointer beyond depth");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push && sp_full |=> $stable(r_sp))
        else $error("push on full stack moved pointer");
    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop_req && !sp_zero |=> r_sp == $past(r_sp) - SPW'(1))
        else $error("pop did not decrement pointer");
endmodule
`default_nettype wire

@@ hw/rtl/rpn_stack_calculator.sv @@
// Top level of the RPN stack calculator: sequencer, datapath and channels.
//
//  channel  | dir | payload                          | handshake
//  i_cmd    | in  | command[3:0], value[31:0] Q16.16 | valid/ready
//  o_res    | out | top[31:0], depth[7:0], status[1:0] | valid/ready
//
// One command at a time; each command steps through its pops, ALU work, pushes and
// top read, and div and mod run through a 48-step divider.
// A stack pop or top read goes through the registered RAM port: request, then capture.
// Reset clears pointer, status and control; the stack RAM is not cleared.
// A result waiting in the output register does not block accepting the next command, only its result load.
`default_nettype none
module rpn_stack_calculator #(
    parameter int DEPTH = rpn_pkg::DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rpn_cmd_if.sink   i_cmd,
    rpn_res_if.source o_res
);
    rpn_pkg::t_dp_ctl ctl;
    rpn_pkg::t_dp_sts sts;

    rpn_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_cmd.valid),
        .i_in_command (i_cmd.command),
        .o_in_ready   (i_cmd.ready),
        .o_out_valid  (o_res.valid),
        .i_out_ready  (o_res.ready),
        .o_ctl        (ctl),
        .i_sts        (sts)
    );

    rpn_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_value  (i_cmd.value),
        .o_sts    (sts),
        .o_top    (o_res.top),
        .o_depth  (o_res.depth),
        .o_status (o_res.status)
    );
endmodule
`default_nettype wire
